>>> rtl/two_class_block_pool_allocator_core_defines.svh
//------------------------------------------------------------------------------
// Assertion macros for the two-class block pool allocator
// Clocked checks with an active-low reset that disables them.
//------------------------------------------------------------------------------
`ifndef TWO_CLASS_BLOCK_POOL_ALLOCATOR_CORE_DEFINES_SVH
`define TWO_CLASS_BLOCK_POOL_ALLOCATOR_CORE_DEFINES_SVH

// check that a holds in the cycle after c
`define TCBPA_ASSERT_NEXT(label, clk, rst_n, c, a) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (c) |=> (a)) \
        else $error("assertion failed: next-cycle check");

// check that a holds in the same cycle as c
`define TCBPA_ASSERT_NOW(label, clk, rst_n, c, a) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (c) |-> (a)) \
        else $error("assertion failed: same-cycle check");

`endif

>>> rtl/tcbpa_pkg.sv
//------------------------------------------------------------------------------
// Two-class block pool allocator package
// Request and response types, status codes, register map and defaults.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcbpa_pkg;

    localparam int SMALL_BLOCKS_DEF = 16;
    localparam int LARGE_BLOCKS_DEF = 8;

    localparam int SIZE_W  = 16;
    localparam int SLOT_W  = 4;
    localparam int SCNT_W  = 5;
    localparam int LCNT_W  = 4;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [SIZE_W-1:0] SMALL_LIMIT_RST = 16'd32;
    localparam logic [SIZE_W-1:0] LARGE_LIMIT_RST = 16'd256;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_SIZE  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic POOL_SMALL = 1'b0;
    localparam logic POOL_LARGE = 1'b1;

    // register select is address bit 2: small_limit at 0, large_limit at 4
    localparam logic REG_SMALL_LIMIT = 1'b0;
    localparam logic REG_LARGE_LIMIT = 1'b1;

    typedef struct packed {
        logic              command;
        logic [SIZE_W-1:0] request_size;
        logic              free_pool;
        logic [SLOT_W-1:0] free_slot;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic              granted_pool;
        logic [SLOT_W-1:0] granted_slot;
        logic [SCNT_W-1:0] small_in_use;
        logic [LCNT_W-1:0] large_in_use;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic exec;
    } t_ctl;

    typedef struct packed {
        logic [SIZE_W-1:0] small_limit;
        logic [SIZE_W-1:0] large_limit;
    } t_cfg;

endpackage

>>> rtl/tcbpa_regs.sv
//------------------------------------------------------------------------------
// Two-class block pool allocator configuration registers
// APB-style write and read of the two size limits.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcbpa_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tcbpa_pkg::PADDR_W-1:0]  paddr,
    input  logic [tcbpa_pkg::PDATA_W-1:0]  pwdata,
    output logic [tcbpa_pkg::PDATA_W-1:0]  prdata,
    output logic                           pready,
    output tcbpa_pkg::t_cfg                o_cfg
);

    logic [tcbpa_pkg::SIZE_W-1:0] r_small_limit;
    logic [tcbpa_pkg::SIZE_W-1:0] r_large_limit;
    logic                         wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_small_limit <= tcbpa_pkg::SMALL_LIMIT_RST;
            r_large_limit <= tcbpa_pkg::LARGE_LIMIT_RST;
        end else if (wr_en) begin
            if (paddr[2] == tcbpa_pkg::REG_SMALL_LIMIT) begin
                r_small_limit <= pwdata[tcbpa_pkg::SIZE_W-1:0];
            end else begin
                r_large_limit <= pwdata[tcbpa_pkg::SIZE_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == tcbpa_pkg::REG_LARGE_LIMIT) begin
            prdata = tcbpa_pkg::PDATA_W'(r_large_limit);
        end else begin
            prdata = tcbpa_pkg::PDATA_W'(r_small_limit);
        end
    end

    assign o_cfg.small_limit = r_small_limit;
    assign o_cfg.large_limit = r_large_limit;

endmodule

>>> rtl/tcbpa_ctrl.sv
//------------------------------------------------------------------------------
// Two-class block pool allocator controller
// Accepts a request, runs the execute state and strobes the response.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcbpa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    output logic            o_done,
    output tcbpa_pkg::t_ctl o_ctl
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_done;
    logic   n_done;
    logic   accept;

    assign accept = i_start && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign o_busy     = (r_state == S_EXEC);
    assign o_done     = r_done;
    assign o_ctl.load = accept;
    assign o_ctl.exec = (r_state == S_EXEC);

endmodule

>>> rtl/tcbpa_datapath.sv
//------------------------------------------------------------------------------
// Two-class block pool allocator datapath
// Used-bit maps, in-use counters, first-free search and response register.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcbpa_datapath #(
    parameter int SMALL_BLOCKS = tcbpa_pkg::SMALL_BLOCKS_DEF,
    parameter int LARGE_BLOCKS = tcbpa_pkg::LARGE_BLOCKS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tcbpa_pkg::t_ctl i_ctl,
    input  tcbpa_pkg::t_cfg i_cfg,
    input  tcbpa_pkg::t_req i_req,
    output tcbpa_pkg::t_rsp o_rsp
);

    localparam int SC_W = $clog2(SMALL_BLOCKS + 1);
    localparam int LC_W = $clog2(LARGE_BLOCKS + 1);
    localparam logic [tcbpa_pkg::SLOT_W:0] SMALL_N = (tcbpa_pkg::SLOT_W + 1)'(SMALL_BLOCKS);
    localparam logic [tcbpa_pkg::SLOT_W:0] LARGE_N = (tcbpa_pkg::SLOT_W + 1)'(LARGE_BLOCKS);

    tcbpa_pkg::t_req           r_req;
    tcbpa_pkg::t_rsp           r_rsp;
    tcbpa_pkg::t_rsp           n_rsp;
    logic [SMALL_BLOCKS-1:0]   r_small_map;
    logic [SMALL_BLOCKS-1:0]   n_small_map;
    logic [LARGE_BLOCKS-1:0]   r_large_map;
    logic [LARGE_BLOCKS-1:0]   n_large_map;
    logic [SC_W-1:0]           r_small_cnt;
    logic [SC_W-1:0]           n_small_cnt;
    logic [LC_W-1:0]           r_large_cnt;
    logic [LC_W-1:0]           n_large_cnt;

    logic [SMALL_BLOCKS-1:0]   s_free;
    logic [SMALL_BLOCKS-1:0]   s_pick;
    logic [SMALL_BLOCKS-1:0]   s_clr;
    logic [LARGE_BLOCKS-1:0]   l_free;
    logic [LARGE_BLOCKS-1:0]   l_pick;
    logic [LARGE_BLOCKS-1:0]   l_clr;
    logic [tcbpa_pkg::SLOT_W-1:0] s_slot;
    logic [tcbpa_pkg::SLOT_W-1:0] l_slot;
    logic                      small_sel;
    logic                      large_sel;
    logic [tcbpa_pkg::SLOT_W:0] slot_ext;
    logic [tcbpa_pkg::SCNT_W:0] l_cnt_ext;

    // lowest free slot as a one-hot mask
    assign s_free = ~r_small_map;
    assign l_free = ~r_large_map;
    assign s_pick = s_free & (~s_free + SMALL_BLOCKS'(1));
    assign l_pick = l_free & (~l_free + LARGE_BLOCKS'(1));

    always_comb begin
        s_slot = '0;
        for (int i = 0; i < SMALL_BLOCKS; i++) begin
            if (s_pick[i]) begin
                s_slot = s_slot | tcbpa_pkg::SLOT_W'(i);
            end
            s_clr[i] = (r_req.free_slot == tcbpa_pkg::SLOT_W'(i));
        end
    end

    always_comb begin
        l_slot = '0;
        for (int i = 0; i < LARGE_BLOCKS; i++) begin
            if (l_pick[i]) begin
                l_slot = l_slot | tcbpa_pkg::SLOT_W'(i);
            end
            l_clr[i] = (r_req.free_slot == tcbpa_pkg::SLOT_W'(i));
        end
    end

    assign small_sel = r_req.request_size < i_cfg.small_limit;
    assign large_sel = !small_sel && (r_req.request_size < i_cfg.large_limit);
    assign slot_ext  = {1'b0, r_req.free_slot};

    always_comb begin
        n_small_map         = r_small_map;
        n_large_map         = r_large_map;
        n_small_cnt         = r_small_cnt;
        n_large_cnt         = r_large_cnt;
        n_rsp.status        = tcbpa_pkg::ST_OK;
        n_rsp.granted_pool  = tcbpa_pkg::POOL_SMALL;
        n_rsp.granted_slot  = '0;
        if (r_req.command == tcbpa_pkg::CMD_ALLOC) begin
            if (small_sel) begin
                if (|s_free) begin
                    n_small_map        = r_small_map | s_pick;
                    n_small_cnt        = r_small_cnt + SC_W'(1);
                    n_rsp.granted_slot = s_slot;
                end else begin
                    n_rsp.status = tcbpa_pkg::ST_FULL;
                end
            end else if (large_sel) begin
                n_rsp.granted_pool = tcbpa_pkg::POOL_LARGE;
                if (|l_free) begin
                    n_large_map        = r_large_map | l_pick;
                    n_large_cnt        = r_large_cnt + LC_W'(1);
                    n_rsp.granted_slot = l_slot;
                end else begin
                    n_rsp.status = tcbpa_pkg::ST_FULL;
                end
            end else begin
                n_rsp.status = tcbpa_pkg::ST_SIZE;
            end
        end else if (r_req.free_pool == tcbpa_pkg::POOL_LARGE) begin
            if (slot_ext >= LARGE_N) begin
                n_rsp.status = tcbpa_pkg::ST_RANGE;
            end else if (|(r_large_map & l_clr)) begin
                n_large_map = r_large_map & ~l_clr;
                n_large_cnt = r_large_cnt - LC_W'(1);
            end
        end else begin
            if (slot_ext >= SMALL_N) begin
                n_rsp.status = tcbpa_pkg::ST_RANGE;
            end else if (|(r_small_map & s_clr)) begin
                n_small_map = r_small_map & ~s_clr;
                n_small_cnt = r_small_cnt - SC_W'(1);
            end
        end
        // saturate the large count to the field width
        l_cnt_ext          = (tcbpa_pkg::SCNT_W + 1)'(n_large_cnt);
        n_rsp.small_in_use = tcbpa_pkg::SCNT_W'(n_small_cnt);
        n_rsp.large_in_use = (l_cnt_ext > (tcbpa_pkg::SCNT_W + 1)'(15)) ?
                             {tcbpa_pkg::LCNT_W{1'b1}} : l_cnt_ext[tcbpa_pkg::LCNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_small_map <= '0;
            r_large_map <= '0;
            r_small_cnt <= '0;
            r_large_cnt <= '0;
        end else if (i_ctl.exec) begin
            r_small_map <= n_small_map;
            r_large_map <= n_large_map;
            r_small_cnt <= n_small_cnt;
            r_large_cnt <= n_large_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_req <= i_req;
        end
        if (i_ctl.exec) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp = r_rsp;

endmodule

>>> rtl/two_class_block_pool_allocator_core.sv
// A request accepted by the controller is captured in the request register, and in
// the execute state the response register and the o_done strobe are loaded.
// No new request is accepted while busy in the execute state, which updates the
// used-bit maps and counters.
// Reset: synchronous, active low; both pools come out all free, limits at 32 and 256.
// The response stays on o_rsp; o_done is high for one cycle and cannot be stalled.
//------------------------------------------------------------------------------
// Two-class block pool allocator core
// Top level: configuration registers, controller and allocator datapath.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "two_class_block_pool_allocator_core_defines.svh"

module two_class_block_pool_allocator_core #(
    parameter int SMALL_BLOCKS = tcbpa_pkg::SMALL_BLOCKS_DEF,
    parameter int LARGE_BLOCKS = tcbpa_pkg::LARGE_BLOCKS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  tcbpa_pkg::t_req               i_req,
    output logic                          o_done,
    output tcbpa_pkg::t_rsp               o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcbpa_pkg::PADDR_W-1:0] paddr,
    input  logic [tcbpa_pkg::PDATA_W-1:0] pwdata,
    output logic [tcbpa_pkg::PDATA_W-1:0] prdata,
    output logic                          pready
);

    tcbpa_pkg::t_cfg cfg;
    tcbpa_pkg::t_ctl ctl;

    tcbpa_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tcbpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_ctl   (ctl)
    );

    tcbpa_datapath #(
        .SMALL_BLOCKS (SMALL_BLOCKS),
        .LARGE_BLOCKS (LARGE_BLOCKS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_cfg   (cfg),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

    `TCBPA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy && !o_done)
    `TCBPA_ASSERT_NEXT(a_busy_done, i_clk, i_rst_n, busy, o_done && !busy)
    `TCBPA_ASSERT_NOW(a_small_count, i_clk, i_rst_n, o_done, o_rsp.small_in_use <= tcbpa_pkg::SCNT_W'(SMALL_BLOCKS))
    `TCBPA_ASSERT_NOW(a_full_slot, i_clk, i_rst_n, o_done && (o_rsp.status == tcbpa_pkg::ST_FULL), o_rsp.granted_slot == '0)

endmodule
